/* hw/rtl/rid_pkg.sv */
package rid_pkg;

    // width of the dividend, divisor, quotient and remainder ports
    localparam int FIELD_W = 32;

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic valid;
        logic dbz;
    } ctl_t;

endpackage

/* hw/rtl/rid_stage.sv */
module rid_stage #(
    parameter int WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rid_pkg::ctl_t     ctl_in,
    input  logic [WIDTH-1:0]  rem_in,
    input  logic [WIDTH-1:0]  num_in,
    input  logic [WIDTH-1:0]  den_in,
    output rid_pkg::ctl_t     ctl_out,
    output logic [WIDTH-1:0]  rem_out,
    output logic [WIDTH-1:0]  num_out,
    output logic [WIDTH-1:0]  den_out
);
    import rid_pkg::*;

    ctl_t             ctl_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] num_reg;
    logic [WIDTH-1:0] den_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             no_borrow;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] num_next;

    // shift the next dividend bit into the partial remainder, keep the bit shifted out on top
    assign trial     = {rem_in, num_in[WIDTH-1]};
    assign diff      = trial - {1'b0, den_in};
    assign no_borrow = ~diff[WIDTH];

    // restore on borrow; quotient bit enters at the bottom as the dividend bits shift up
    assign rem_next = no_borrow ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    assign num_next = {num_in[WIDTH-2:0], no_borrow};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule

/* hw/rtl/restoring_integer_divider.sv */
// Pipelined unsigned restoring divider.
// Request: raise start with dividend and divisor; the request is taken at any
// rising edge where start is high and busy is low. busy stays low, so a new
// request can be taken in every cycle.
// Result: done is high for one cycle with quotient, remainder and
// divide_by_zero; the receiver must take it in that cycle.
// Pipeline: one input register, one stage per quotient bit, one output
// register. Throughput: one request per cycle; each stage holds one
// WIDTH+1 bit subtract and compare, so the depth of the pipeline follows WIDTH.
// Only the low WIDTH bits of dividend and divisor are used; a zero divisor
// gives divide_by_zero with zero quotient and remainder.
// Reset: rst_n clears all valid bits at once; requests in flight are dropped
// and done stays low until a new request has passed the pipeline.
// Results leave in request order and are never held back.
module restoring_integer_divider #(
    parameter int WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rid_pkg::FIELD_W-1:0] dividend,
    input  logic [rid_pkg::FIELD_W-1:0] divisor,
    output logic                        done,
    output logic [rid_pkg::FIELD_W-1:0] quotient,
    output logic [rid_pkg::FIELD_W-1:0] remainder,
    output logic                        divide_by_zero
);
    import rid_pkg::*;

    localparam int LAT = WIDTH + 2;

    logic [WIDTH+FIELD_W-1:0] num_ext;
    logic [WIDTH+FIELD_W-1:0] den_ext;
    logic [WIDTH-1:0]         num_in;
    logic [WIDTH-1:0]         den_in;

    ctl_t             in_ctl_reg;
    ctl_t             in_ctl_next;
    logic [WIDTH-1:0] in_num_reg;
    logic [WIDTH-1:0] in_den_reg;

    ctl_t             ctl_pipe [WIDTH+1];
    logic [WIDTH-1:0] rem_pipe [WIDTH+1];
    logic [WIDTH-1:0] num_pipe [WIDTH+1];
    logic [WIDTH-1:0] den_pipe [WIDTH+1];

    ctl_t                     out_ctl_reg;
    logic [WIDTH-1:0]         out_quo_reg;
    logic [WIDTH-1:0]         out_rem_reg;
    logic [WIDTH-1:0]         out_quo_next;
    logic [WIDTH-1:0]         out_rem_next;
    logic [WIDTH+FIELD_W-1:0] quo_ext;
    logic [WIDTH+FIELD_W-1:0] rem_ext;

    assign busy = 1'b0;

    // drop input bits above WIDTH, zero-extend when WIDTH is wider than the ports
    assign num_ext = {{WIDTH{1'b0}}, dividend};
    assign den_ext = {{WIDTH{1'b0}}, divisor};
    assign num_in  = num_ext[WIDTH-1:0];
    assign den_in  = den_ext[WIDTH-1:0];

    assign in_ctl_next.valid = start & ~busy;
    assign in_ctl_next.dbz   = (den_in == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else
        begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_num_reg <= num_in;
        in_den_reg <= den_in;
    end

    assign ctl_pipe[0] = in_ctl_reg;
    assign rem_pipe[0] = '0;
    assign num_pipe[0] = in_num_reg;
    assign den_pipe[0] = in_den_reg;

    for (genvar s = 0; s < WIDTH; s++)
    begin : g_stage
        rid_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_pipe[s]),
            .rem_in  (rem_pipe[s]),
            .num_in  (num_pipe[s]),
            .den_in  (den_pipe[s]),
            .ctl_out (ctl_pipe[s+1]),
            .rem_out (rem_pipe[s+1]),
            .num_out (num_pipe[s+1]),
            .den_out (den_pipe[s+1])
        );
    end

    // force zero results on a zero divisor
    assign out_quo_next = ctl_pipe[WIDTH].dbz ? '0 : num_pipe[WIDTH];
    assign out_rem_next = ctl_pipe[WIDTH].dbz ? '0 : rem_pipe[WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else
        begin
            out_ctl_reg <= ctl_pipe[WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        out_quo_reg <= out_quo_next;
        out_rem_reg <= out_rem_next;
    end

    assign quo_ext = {{FIELD_W{1'b0}}, out_quo_reg};
    assign rem_ext = {{FIELD_W{1'b0}}, out_rem_reg};

    assign done           = out_ctl_reg.valid;
    assign quotient       = quo_ext[FIELD_W-1:0];
    assign remainder      = rem_ext[FIELD_W-1:0];
    assign divide_by_zero = out_ctl_reg.dbz;

    a_done_follows_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT)
    ) else $error("result without a request LAT cycles earlier");

    a_dbz_zero_results: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (quotient == '0 && remainder == '0)
    ) else $error("nonzero result on divide by zero");

    a_rem_below_divisor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !divide_by_zero) |-> (remainder < $past(divisor, LAT))
    ) else $error("remainder not below divisor");

    a_dbz_only_on_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> ($past(den_in, LAT) == '0)
    ) else $error("divide by zero flagged on nonzero divisor");

endmodule

/* test/restoring_integer_divider_test.sv */
module restoring_integer_divider_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rid_pkg::*;

    localparam int WIDTH           = 32;
    localparam int LATENCY         = WIDTH + 2;
    localparam int RANDOM_REQUESTS = 1730;
    localparam int MAX_GAP         = 19;

    typedef logic [FIELD_W-1:0] word_t;

    typedef struct {
        word_t quotient;
        word_t remainder;
        logic  dbz;
    } division_t;

    class division_scoreboard;
        division_t pending_divisions[$];
        int        errors;
        int        requests;
        int        zero_divisors;
        int        checked;

        // restoring division at WIDTH+1 bits, one quotient bit per pass
        function division_t divide(word_t num, word_t den);
            division_t        res;
            logic [WIDTH-1:0] n;
            logic [WIDTH-1:0] d;
            logic [WIDTH-1:0] q;
            logic [WIDTH:0]   part;
            n = num[WIDTH-1:0];
            d = den[WIDTH-1:0];
            q = '0;
            part = '0;
            res.quotient = '0;
            res.remainder = '0;
            res.dbz = 1'b0;
            if (d == '0)
            begin
                res.dbz = 1'b1;
                return res;
            end
            for (int i = WIDTH - 1; i >= 0; i--)
            begin
                part = {part[WIDTH-1:0], n[i]};
                if (part >= {1'b0, d})
                begin
                    part = part - {1'b0, d};
                    q[i] = 1'b1;
                end
            end
            res.quotient = word_t'(q);
            res.remainder = word_t'(part[WIDTH-1:0]);
            return res;
        endfunction

        function void note_request(word_t num, word_t den);
            division_t res;
            res = divide(num, den);
            requests++;
            if (res.dbz)
                zero_divisors++;
            pending_divisions.push_back(res);
        endfunction

        function void check_result(word_t q, word_t r, logic dbz);
            division_t want;
            if (pending_divisions.size() == 0)
            begin
                $error("result with no request outstanding: quotient %h remainder %h dbz %b",
                       q, r, dbz);
                errors++;
                return;
            end
            want = pending_divisions.pop_front();
            checked++;
            if (q !== want.quotient)
            begin
                $error("quotient: expected %h, got %h", want.quotient, q);
                errors++;
            end
            if (r !== want.remainder)
            begin
                $error("remainder: expected %h, got %h", want.remainder, r);
                errors++;
            end
            if (dbz !== want.dbz)
            begin
                $error("divide_by_zero: expected %b, got %b", want.dbz, dbz);
                errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t dividend;
    word_t divisor;
    logic  done;
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;

    division_scoreboard divisions = new;
    bit                 burst;

    restoring_integer_divider #(
        .WIDTH(WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .dividend      (dividend),
        .divisor       (divisor),
        .done          (done),
        .quotient      (quotient),
        .remainder     (remainder),
        .divide_by_zero(divide_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("restoring_integer_divider_test: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            divisions.check_result(quotient, remainder, divide_by_zero);
    end

    // hold the request until taken; start stays high across back-to-back requests
    task automatic send_request(word_t num, word_t den, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        dividend <= num;
        divisor  <= den;
        do @(posedge clk); while (busy);
        divisions.note_request(num, den);
    endtask

    function automatic int pick_gap();
        if (burst)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void random_operands(output word_t num, output word_t den);
        case ($urandom_range(0, 9))
            0:
            begin
                num = $urandom;
                den = $urandom_range(1, 15);
            end
            1:
            begin
                num = $urandom;
                den = '0;
            end
            2:
            begin
                den = $urandom_range(1, 32'hFFFF_FFFF);
                num = $urandom_range(0, den - 1);
            end
            3:
            begin
                num = $urandom >> $urandom_range(0, 31);
                den = $urandom >> $urandom_range(0, 31);
            end
            4:
            begin
                num = $urandom;
                den = word_t'(1) << $urandom_range(0, 31);
            end
            5:
            begin
                den = $urandom >> $urandom_range(8, 31);
                if (den == '0)
                    den = 1;
                num = den * $urandom_range(0, 255) + $urandom_range(0, 3);
            end
            6:
            begin
                num = $urandom;
                den = $urandom | 32'h8000_0000;
            end
            default:
            begin
                num = $urandom;
                den = $urandom;
            end
        endcase
    endfunction

    initial
    begin
        word_t num;
        word_t den;
        word_t edge_num[];
        word_t edge_den[];
        int    waited;

        edge_num = {32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h1, 32'h1234_5678, 32'h8000_0000, 32'h8000_0000,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0064,
                    32'h0000_0007, 32'hDEAD_BEEF, 32'h8000_0001, 32'hFFFF_FFFF,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000};
        edge_den = {32'h0, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'h0,
                    32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0001,
                    32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0064,
                    32'h0000_0003, 32'h0000_0010, 32'h0000_0002, 32'h0000_0002,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};

        rst_n    = 1'b0;
        start    = 1'b0;
        dividend = '0;
        divisor  = '0;
        burst    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge values: zero divisor, all ones, top bit, equal operands, divisor above dividend
        foreach (edge_num[i])
            send_request(edge_num[i], edge_den[i], $urandom_range(0, 3));

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            random_operands(num, den);
            send_request(num, den, pick_gap());
        end
        start <= 1'b0;

        waited = 0;
        while (divisions.pending_divisions.size() != 0 && waited < 20 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (divisions.pending_divisions.size() != 0)
        begin
            $error("%0d requests never returned a result", divisions.pending_divisions.size());
            divisions.errors++;
        end

        $display("ran %0d divisions, %0d of them by zero, back-to-back bursts mixed with gaps",
                 divisions.requests, divisions.zero_divisors);
        $display("compared %0d results, %0d mismatches", divisions.checked, divisions.errors);
        if (divisions.errors == 0)
            $display("restoring_integer_divider_test: PASS");
        else
            $display("restoring_integer_divider_test: FAIL");
        $finish;
    end

endmodule
